FILE: design/mcpi_pkg.sv
package mcpi_pkg;

  // Mode command codes carried by each input word.
  localparam logic [2:0] CMD_KEEP     = 3'd0;
  localparam logic [2:0] CMD_IDLE     = 3'd1;
  localparam logic [2:0] CMD_MANUAL   = 3'd2;
  localparam logic [2:0] CMD_SELFTEST = 3'd3;
  localparam logic [2:0] CMD_HOLD     = 3'd4;
  localparam logic [2:0] CMD_TRACK    = 3'd5;

  // Configuration register indexes.
  localparam logic [2:0] REG_PROP_GAIN   = 3'd0;
  localparam logic [2:0] REG_INTEG_GAIN  = 3'd1;
  localparam logic [2:0] REG_MANUAL_DUTY = 3'd2;
  localparam logic [2:0] REG_PWM_PERIOD  = 3'd3;
  localparam logic [2:0] REG_TEST_AMP    = 3'd4;
  localparam logic [2:0] REG_HOLD_TICKS  = 3'd5;

  // Operating mode as reported on the result word.
  typedef enum logic [2:0] {
    MODE_IDLE     = 3'd0,
    MODE_MANUAL   = 3'd1,
    MODE_SELFTEST = 3'd2,
    MODE_HOLD     = 3'd3,
    MODE_TRACK    = 3'd4
  } mode_e;

  // Datapath widths.
  localparam int unsigned ErrW   = 14;
  localparam int unsigned IntegW = 32;
  localparam int unsigned MulAW  = 33;
  localparam int unsigned MulBW  = 25;
  localparam int unsigned AccW   = MulAW + MulBW;
  localparam int unsigned FracW  = 16;
  localparam int unsigned CountW = 14;

  // Self-test run length in ticks.
  localparam logic [CountW-1:0] TEST_LENGTH = 14'd100;

  // Duty limit in percent.
  localparam logic signed [7:0] DUTY_MAX = 8'sd100;
  localparam logic signed [7:0] DUTY_MIN = -8'sd100;

  // floor(x/100) = (x * RECIP_100) >> RECIP_SHIFT, exact for x below 2^24.
  localparam logic [24:0] RECIP_100   = 25'd21474837;
  localparam int unsigned RECIP_SHIFT = 31;

endpackage

FILE: design/motor_current_pi_loop_modes.sv
// Channel  | Direction | Handshake                | Word
// ---------+-----------+--------------------------+----------------------------------------
// in       | input     | in_valid_i / in_stall_o  | mode, measured and reference current
// out      | output    | out_valid_o / out_stall_i| compare, direction, duty, mode, ref, done
// cfg      | input     | cfg_valid_i / cfg_ready_o| register index and write data
//
// A loop tick word is accepted in idle and steps through command, reference, integral,
// proportional multiply, integral multiply, duty, scale and divide before it loads the output
// register; no new word is taken until the sequencer is idle again. The multiplier steps run
// through one shared 33x25 multiplier (proportional term, integral term, duty times period, then
// a reciprocal multiply for the divide by 100). Idle ticks skip the multiplier; manual ticks skip the PI steps.
// Reset is asynchronous and active low; it restores register defaults and clears all loop state.
// A stalled result holds in the output register; the next input word is accepted meanwhile
// and the sequencer waits only at its final step until the output register is free.
module motor_current_pi_loop_modes
  import mcpi_pkg::*;
#(
  parameter int unsigned TEST_HALF_PERIOD = 25
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Tick input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         mode_i,
  input  logic signed [12:0] measured_current_i,
  input  logic signed [10:0] outer_ref_current_i,
  // Result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [16:0]        compare_value_o,
  output logic               direction_o,
  output logic signed [7:0]  duty_o,
  output logic [2:0]         operating_mode_o,
  output logic signed [12:0] reference_current_o,
  output logic               run_done_o,
  // Configuration write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [23:0]        cfg_data_i
);

  localparam int unsigned PhW = (TEST_HALF_PERIOD > 1) ? $clog2(TEST_HALF_PERIOD) : 1;
  localparam logic [PhW-1:0] PhLast = PhW'(TEST_HALF_PERIOD - 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_CMD, ST_REF, ST_INTEG, ST_MULP, ST_MULI, ST_DUTY, ST_SCALE, ST_DIV, ST_OUT
  } state_e;

  state_e state_q;

  // Configuration registers
  logic [23:0]       prop_gain_q, integ_gain_q;
  logic signed [7:0] manual_duty_q;
  logic [16:0]       pwm_period_q;
  logic [11:0]       test_amp_q;
  logic [13:0]       hold_ticks_q;

  // Loop state
  mode_e                    mode_q;
  logic [CountW-1:0]        sample_cnt_q;
  logic [PhW-1:0]           phase_q;
  logic                     tpos_q;
  logic signed [IntegW-1:0] test_integ_q, hold_integ_q, track_integ_q;

  // Captured input word and working registers
  logic [2:0]               cmd_q;
  logic signed [12:0]       meas_q;
  logic signed [10:0]       outer_q;
  logic signed [ErrW-1:0]   err_q;
  logic signed [IntegW-1:0] sum_q;
  logic signed [AccW-1:0]   acc_q;
  logic signed [7:0]        duty_q;
  logic signed [12:0]       refc_q;
  logic [16:0]              cmp_q;
  logic                     drive_q, done_q;

  // Output register
  logic                     out_valid_q;
  logic [16:0]              out_cmp_q;
  logic                     out_dir_q;
  logic signed [7:0]        out_duty_q;
  logic [2:0]               out_mode_q;
  logic signed [12:0]       out_ref_q;
  logic                     out_done_q;

  // Combinational signals
  logic signed [MulAW-1:0]  mul_a;
  logic signed [MulBW-1:0]  mul_b;
  logic signed [AccW-1:0]   mul_p;
  logic                     tpos_next;
  logic signed [12:0]       ref_sel;
  logic signed [ErrW-1:0]   err_d;
  logic signed [IntegW-1:0] integ_sel;
  logic signed [IntegW:0]   sum_wide;
  logic signed [IntegW-1:0] sum_sat;
  logic signed [AccW-1:0]   acc_biased;
  logic signed [AccW-FracW-1:0] duty_wide;
  logic signed [7:0]        duty_clamped;
  logic signed [7:0]        manual_clamped;
  logic [6:0]               duty_mag;
  logic [CountW-1:0]        cnt_next;
  logic [PhW-1:0]           phase_next;
  logic                     out_free;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;

  // Shared multiplier: operands chosen by the sequencer step.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_MULP: begin
        mul_a = MulAW'(err_q);
        mul_b = {1'b0, prop_gain_q};
      end
      ST_MULI: begin
        mul_a = MulAW'(sum_q);
        mul_b = {1'b0, integ_gain_q};
      end
      ST_SCALE: begin
        mul_a = {16'd0, pwm_period_q};
        mul_b = {18'd0, duty_mag};
      end
      ST_DIV: begin
        mul_a = {8'd0, RECIP_100};
        mul_b = {1'b0, acc_q[23:0]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = AccW'(mul_a) * AccW'(mul_b);
  end

  // Reference selection and current error.
  always_comb begin
    tpos_next = (phase_q == '0) ? !tpos_q : tpos_q;
    case (mode_q)
      MODE_SELFTEST: ref_sel = tpos_next ? $signed({1'b0, test_amp_q})
                                         : -$signed({1'b0, test_amp_q});
      MODE_HOLD, MODE_TRACK: ref_sel = 13'(outer_q);
      default: ref_sel = '0;
    endcase
    err_d = ErrW'(ref_sel) - ErrW'(meas_q);
  end

  // Saturating integral update for the active loop mode.
  always_comb begin
    case (mode_q)
      MODE_SELFTEST: integ_sel = test_integ_q;
      MODE_HOLD:     integ_sel = hold_integ_q;
      default:       integ_sel = track_integ_q;
    endcase
    sum_wide = (IntegW + 1)'(integ_sel) + (IntegW + 1)'(err_q);
    if (sum_wide[IntegW] != sum_wide[IntegW-1]) begin
      sum_sat = sum_wide[IntegW] ? {1'b1, {(IntegW - 1){1'b0}}} : {1'b0, {(IntegW - 1){1'b1}}};
    end else begin
      sum_sat = sum_wide[IntegW-1:0];
    end
    cnt_next   = sample_cnt_q + 1'b1;
    phase_next = (phase_q == PhLast) ? '0 : phase_q + 1'b1;
  end

  // Duty from the Q.16 sum, truncated toward zero and clamped.
  always_comb begin
    acc_biased = acc_q + (acc_q[AccW-1] ? AccW'(17'h0FFFF) : '0);
    duty_wide  = acc_biased[AccW-1:FracW];
    if (duty_wide > (AccW - FracW)'(DUTY_MAX)) begin
      duty_clamped = DUTY_MAX;
    end else if (duty_wide < (AccW - FracW)'(DUTY_MIN)) begin
      duty_clamped = DUTY_MIN;
    end else begin
      duty_clamped = duty_wide[7:0];
    end
    if (manual_duty_q > DUTY_MAX) begin
      manual_clamped = DUTY_MAX;
    end else if (manual_duty_q < DUTY_MIN) begin
      manual_clamped = DUTY_MIN;
    end else begin
      manual_clamped = manual_duty_q;
    end
    duty_mag = duty_q[7] ? 7'(-duty_q) : duty_q[6:0];
  end

  // Sequencer, loop state, configuration and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      prop_gain_q   <= 24'd3277;
      integ_gain_q  <= 24'd3277;
      manual_duty_q <= '0;
      pwm_period_q  <= 17'd2400;
      test_amp_q    <= 12'd200;
      hold_ticks_q  <= 14'd12500;
      mode_q        <= MODE_IDLE;
      sample_cnt_q  <= '0;
      phase_q       <= '0;
      tpos_q        <= 1'b0;
      test_integ_q  <= '0;
      hold_integ_q  <= '0;
      track_integ_q <= '0;
      cmd_q         <= CMD_KEEP;
      meas_q        <= '0;
      outer_q       <= '0;
      err_q         <= '0;
      sum_q         <= '0;
      acc_q         <= '0;
      duty_q        <= '0;
      refc_q        <= '0;
      cmp_q         <= '0;
      drive_q       <= 1'b0;
      done_q        <= 1'b0;
      out_valid_q   <= 1'b0;
      out_cmp_q     <= '0;
      out_dir_q     <= 1'b0;
      out_duty_q    <= '0;
      out_mode_q    <= '0;
      out_ref_q     <= '0;
      out_done_q    <= 1'b0;
    end else begin
      // Configuration writes; indexes past the list are ignored.
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_PROP_GAIN:   prop_gain_q   <= cfg_data_i;
          REG_INTEG_GAIN:  integ_gain_q  <= cfg_data_i;
          REG_MANUAL_DUTY: manual_duty_q <= cfg_data_i[7:0];
          REG_PWM_PERIOD:  pwm_period_q  <= cfg_data_i[16:0];
          REG_TEST_AMP:    test_amp_q    <= cfg_data_i[11:0];
          REG_HOLD_TICKS:  hold_ticks_q  <= cfg_data_i[13:0];
          default: ;
        endcase
      end

      // The result word leaves when the consumer takes it; the final step reloads it itself.
      if (out_valid_q && !out_stall_i && state_q != ST_OUT) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            cmd_q   <= mode_i;
            meas_q  <= measured_current_i;
            outer_q <= outer_ref_current_i;
            state_q <= ST_CMD;
          end
        end

        // Apply a mode command; a change of mode restarts the run counters.
        ST_CMD: begin
          done_q <= 1'b0;
          if (cmd_q != CMD_KEEP && cmd_q <= CMD_TRACK && (cmd_q - 1'b1) != mode_q) begin
            case (cmd_q)
              CMD_IDLE:     mode_q <= MODE_IDLE;
              CMD_MANUAL:   mode_q <= MODE_MANUAL;
              CMD_SELFTEST: mode_q <= MODE_SELFTEST;
              CMD_HOLD:     mode_q <= MODE_HOLD;
              default:      mode_q <= MODE_TRACK;
            endcase
            sample_cnt_q <= '0;
            phase_q      <= '0;
            tpos_q       <= 1'b0;
          end
          state_q <= ST_REF;
        end

        // Pick the reference; idle finishes at once and manual goes straight to the scale step.
        ST_REF: begin
          refc_q <= ref_sel;
          err_q  <= err_d;
          case (mode_q)
            MODE_MANUAL: begin
              duty_q  <= manual_clamped;
              drive_q <= 1'b1;
              state_q <= ST_SCALE;
            end
            MODE_SELFTEST: begin
              tpos_q  <= tpos_next;
              drive_q <= 1'b1;
              state_q <= ST_INTEG;
            end
            MODE_HOLD, MODE_TRACK: begin
              drive_q <= 1'b1;
              state_q <= ST_INTEG;
            end
            default: begin
              mode_q  <= MODE_IDLE;
              duty_q  <= '0;
              cmp_q   <= '0;
              drive_q <= 1'b0;
              state_q <= ST_OUT;
            end
          endcase
        end

        // Integral update and end-of-run check.
        ST_INTEG: begin
          sum_q <= sum_sat;
          case (mode_q)
            MODE_SELFTEST: begin
              if (cnt_next >= TEST_LENGTH) begin
                sample_cnt_q <= '0;
                phase_q      <= '0;
                tpos_q       <= 1'b0;
                test_integ_q <= '0;
                mode_q       <= MODE_IDLE;
                done_q       <= 1'b1;
              end else begin
                sample_cnt_q <= cnt_next;
                phase_q      <= phase_next;
                test_integ_q <= sum_sat;
              end
            end
            MODE_HOLD: begin
              if (cnt_next >= hold_ticks_q) begin
                sample_cnt_q <= '0;
                hold_integ_q <= '0;
                mode_q       <= MODE_IDLE;
                done_q       <= 1'b1;
              end else begin
                sample_cnt_q <= cnt_next;
                hold_integ_q <= sum_sat;
              end
            end
            default: track_integ_q <= sum_sat;
          endcase
          state_q <= ST_MULP;
        end

        ST_MULP: begin
          acc_q   <= mul_p;
          state_q <= ST_MULI;
        end

        ST_MULI: begin
          acc_q   <= acc_q + mul_p;
          state_q <= ST_DUTY;
        end

        ST_DUTY: begin
          duty_q  <= duty_clamped;
          state_q <= ST_SCALE;
        end

        // period * |duty| into the accumulator, then divide by 100.
        ST_SCALE: begin
          acc_q   <= mul_p;
          state_q <= ST_DIV;
        end

        ST_DIV: begin
          cmp_q   <= mul_p[RECIP_SHIFT +: 17];
          state_q <= ST_OUT;
        end

        // Load the output register once it is free.
        ST_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_cmp_q   <= drive_q ? cmp_q : '0;
            out_dir_q   <= drive_q && !duty_q[7];
            out_duty_q  <= duty_q;
            out_mode_q  <= mode_q;
            out_ref_q   <= refc_q;
            out_done_q  <= done_q;
            state_q     <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o         = out_valid_q;
  assign compare_value_o     = out_cmp_q;
  assign direction_o         = out_dir_q;
  assign duty_o              = out_duty_q;
  assign operating_mode_o    = out_mode_q;
  assign reference_current_o = out_ref_q;
  assign run_done_o          = out_done_q;

endmodule
